// File: rtl/ftrm_pkg.sv
// Package: item types, mode codes, list entry formats and sequencer states of the rule matcher.
package ftrm_pkg;

	// Item modes
	localparam logic [2:0] MODE_MATCH     = 3'd0;
	localparam logic [2:0] MODE_CLEAR     = 3'd1;
	localparam logic [2:0] MODE_ADD_SADDR = 3'd2;
	localparam logic [2:0] MODE_ADD_DADDR = 3'd3;
	localparam logic [2:0] MODE_ADD_SPORT = 3'd4;
	localparam logic [2:0] MODE_ADD_DPORT = 3'd5;
	localparam logic [2:0] MODE_ADD_PROTO = 3'd6;

	// Default record values
	localparam logic [7:0]  PROTO_TCP = 8'd6;
	localparam logic [7:0]  PROTO_UDP = 8'd17;
	localparam logic [15:0] PORT_MAX  = 16'hFFFF;

	typedef struct packed {
		logic [2:0]  mode;
		logic [31:0] pkt_src_addr;
		logic [31:0] pkt_dst_addr;
		logic [15:0] pkt_src_port;
		logic [15:0] pkt_dst_port;
		logic [7:0]  pkt_proto;
		logic [31:0] entry_address;
		logic [31:0] entry_mask;
		logic [15:0] entry_port_low;
		logic [15:0] entry_port_high;
		logic [7:0]  entry_proto;
	} ftrm_in_t;

	typedef struct packed {
		logic matched;
		logic rejected;
	} ftrm_out_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [31:0] mask;
	} addr_ent_t;

	typedef struct packed {
		logic [15:0] lo;
		logic [15:0] hi;
	} port_ent_t;

	// One flag per list, used for per-step hits and valid entries
	typedef struct packed {
		logic src_addr;
		logic dst_addr;
		logic src_port;
		logic dst_port;
		logic proto;
	} ftrm_hit_t;

	localparam addr_ent_t ADDR_DEFAULT = '{addr: 32'd0, mask: 32'd0};
	localparam port_ent_t PORT_DEFAULT = '{lo: 16'd0, hi: PORT_MAX};

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

endpackage

// File: rtl/ftrm_list.sv
// One bounded rule list: entry memory, fill count and default-record overlay.
module ftrm_list #(
	parameter int              WIDTH   = 8,
	parameter int              DEPTH   = 8,
	parameter int              IDXW    = 4,
	parameter int              RST_CNT = 1,
	parameter logic [WIDTH-1:0] RST_E0 = '0,
	parameter logic [WIDTH-1:0] RST_E1 = '0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic             clr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [IDXW-1:0]  idx,
	output logic [WIDTH-1:0] rdata,
	output logic             rd_ok,
	output logic             full,
	output logic [IDXW-1:0]  count
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem [DEPTH];
	logic [CW-1:0]    count_q;
	logic             def_q;
	logic [WIDTH-1:0] mem_s1;
	logic [WIDTH-1:0] defv_s1;
	logic             def_s1;
	logic             ok_s1;

	assign full  = (count_q == CW'(DEPTH));
	assign count = IDXW'(count_q);

	// Track fill level; the default record stays overlaid until the first clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CW'(RST_CNT);
			def_q   <= 1'b1;
		end else if (clr) begin
			count_q <= '0;
			def_q   <= 1'b0;
		end else if (wr && !full) begin
			count_q <= count_q + 1'b1;
		end
	end

	// Append an entry at the fill level
	always_ff @(posedge clk) begin
		if (wr && !full) begin
			mem[count_q[AW-1:0]] <= wdata;
		end
	end

	// Registered read, with the default entry and in-range flag alongside
	always_ff @(posedge clk) begin
		mem_s1  <= mem[idx[AW-1:0]];
		def_s1  <= def_q && (idx < IDXW'(RST_CNT));
		defv_s1 <= (idx == '0) ? RST_E0 : RST_E1;
		ok_s1   <= (idx < IDXW'(count_q));
	end

	assign rdata = def_s1 ? defv_s1 : mem_s1;
	assign rd_ok = ok_s1;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("list fill count beyond depth");

	a_append: assert property (@(posedge clk) disable iff (!arst_n)
		(wr && !full && !clr) |=> (count_q == CW'($past(count_q) + 1'b1)))
		else $error("append did not advance fill count");

	a_refuse: assert property (@(posedge clk) disable iff (!arst_n)
		(wr && full && !clr) |=> $stable(count_q))
		else $error("refused append changed fill count");

endmodule

// File: rtl/ftrm_cmp.sv
// Shared compare unit: tests one entry of every list against the packet five-tuple.
module ftrm_cmp (
	input  ftrm_pkg::ftrm_in_t  pkt,
	input  ftrm_pkg::addr_ent_t src_addr,
	input  ftrm_pkg::addr_ent_t dst_addr,
	input  ftrm_pkg::port_ent_t src_port,
	input  ftrm_pkg::port_ent_t dst_port,
	input  logic [7:0]          proto,
	output ftrm_pkg::ftrm_hit_t hit
);

	// Masked address equality, inclusive port range, protocol equality
	always_comb begin
		hit.src_addr = ((pkt.pkt_src_addr & src_addr.mask) == src_addr.addr);
		hit.dst_addr = ((pkt.pkt_dst_addr & dst_addr.mask) == dst_addr.addr);
		hit.src_port = (pkt.pkt_src_port >= src_port.lo) && (pkt.pkt_src_port <= src_port.hi);
		hit.dst_port = (pkt.pkt_dst_port >= dst_port.lo) && (pkt.pkt_dst_port <= dst_port.hi);
		hit.proto    = (pkt.pkt_proto == proto);
	end

endmodule

// File: rtl/five_tuple_rule_matcher.sv
// Top level: five-list classification rule with a sequenced match scan.
//
// Command channel: an item is taken on a rising edge with start high and busy low.
// Result channel: done is high for exactly one cycle with result valid; the
// receiver cannot hold it off, and every item gives exactly one result.
// Add and clear items update the lists at the accepting edge; their result is
// registered at that edge and busy stays low, so such items may follow every cycle.
// A match item walks all five lists together, one entry index per cycle, through
// one compare unit fed by the registered list reads, over N entries, where N is
// the longest fill count (at most the largest list depth, 8 by default). Busy is
// high through the scan and low again while done is high, so the next item can
// be taken from then on.
// Rejected is set when an add finds its list full; matched when every list holds
// an entry accepting the packet. An empty list matches nothing.
// Reset puts the lists in the default record: any address, any port, and the
// protocols 6 and 17. No clearing pass is needed.
module five_tuple_rule_matcher #(
	parameter int ADDR_ENTRIES  = 8,
	parameter int PORT_ENTRIES  = 8,
	parameter int PROTO_ENTRIES = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  ftrm_pkg::ftrm_in_t  cmd,
	output logic                done,
	output ftrm_pkg::ftrm_out_t result
);

	localparam int MAXAP = (ADDR_ENTRIES > PORT_ENTRIES) ? ADDR_ENTRIES : PORT_ENTRIES;
	localparam int MAXD  = (MAXAP > PROTO_ENTRIES) ? MAXAP : PROTO_ENTRIES;
	localparam int IDXW  = $clog2(MAXD + 1);
	localparam int AEW   = $bits(ftrm_pkg::addr_ent_t);
	localparam int PEW   = $bits(ftrm_pkg::port_ent_t);

	ftrm_pkg::state_t    state_q, state_d;
	ftrm_pkg::ftrm_in_t  pkt_q;
	ftrm_pkg::ftrm_hit_t hit_q, hit_cmp, hit_now, ok_s1, full;
	ftrm_pkg::ftrm_out_t result_q;
	ftrm_pkg::addr_ent_t new_addr, sa_ent, da_ent;
	ftrm_pkg::port_ent_t new_port, sp_ent, dp_ent;
	logic [7:0]          pr_ent;
	logic [IDXW-1:0]     idx_q, last_q;
	logic [IDXW-1:0]     sa_cnt, da_cnt, sp_cnt, dp_cnt, pr_cnt;
	logic                vld_s1, done_q;
	logic                accept, is_match, is_add, full_sel;
	logic                scan_end, issue, finish, clr;
	logic                wr_sa, wr_da, wr_sp, wr_dp, wr_pr;

	function automatic logic [IDXW-1:0] max2(input logic [IDXW-1:0] a, input logic [IDXW-1:0] b);
		return (a > b) ? a : b;
	endfunction

	assign busy     = (state_q != ftrm_pkg::ST_IDLE);
	assign accept   = start && !busy;
	assign is_match = (cmd.mode == ftrm_pkg::MODE_MATCH);
	assign clr      = accept && (cmd.mode == ftrm_pkg::MODE_CLEAR);
	assign wr_sa    = accept && (cmd.mode == ftrm_pkg::MODE_ADD_SADDR);
	assign wr_da    = accept && (cmd.mode == ftrm_pkg::MODE_ADD_DADDR);
	assign wr_sp    = accept && (cmd.mode == ftrm_pkg::MODE_ADD_SPORT);
	assign wr_dp    = accept && (cmd.mode == ftrm_pkg::MODE_ADD_DPORT);
	assign wr_pr    = accept && (cmd.mode == ftrm_pkg::MODE_ADD_PROTO);

	assign new_addr = '{addr: cmd.entry_address, mask: cmd.entry_mask};
	assign new_port = '{lo: cmd.entry_port_low, hi: cmd.entry_port_high};

	ftrm_list #(
		.WIDTH(AEW), .DEPTH(ADDR_ENTRIES), .IDXW(IDXW), .RST_CNT(1),
		.RST_E0(ftrm_pkg::ADDR_DEFAULT), .RST_E1(ftrm_pkg::ADDR_DEFAULT)
	) u_src_addr (
		.clk(clk), .arst_n(arst_n), .wr(wr_sa), .clr(clr), .wdata(new_addr),
		.idx(idx_q), .rdata(sa_ent), .rd_ok(ok_s1.src_addr), .full(full.src_addr),
		.count(sa_cnt)
	);

	ftrm_list #(
		.WIDTH(AEW), .DEPTH(ADDR_ENTRIES), .IDXW(IDXW), .RST_CNT(1),
		.RST_E0(ftrm_pkg::ADDR_DEFAULT), .RST_E1(ftrm_pkg::ADDR_DEFAULT)
	) u_dst_addr (
		.clk(clk), .arst_n(arst_n), .wr(wr_da), .clr(clr), .wdata(new_addr),
		.idx(idx_q), .rdata(da_ent), .rd_ok(ok_s1.dst_addr), .full(full.dst_addr),
		.count(da_cnt)
	);

	ftrm_list #(
		.WIDTH(PEW), .DEPTH(PORT_ENTRIES), .IDXW(IDXW), .RST_CNT(1),
		.RST_E0(ftrm_pkg::PORT_DEFAULT), .RST_E1(ftrm_pkg::PORT_DEFAULT)
	) u_src_port (
		.clk(clk), .arst_n(arst_n), .wr(wr_sp), .clr(clr), .wdata(new_port),
		.idx(idx_q), .rdata(sp_ent), .rd_ok(ok_s1.src_port), .full(full.src_port),
		.count(sp_cnt)
	);

	ftrm_list #(
		.WIDTH(PEW), .DEPTH(PORT_ENTRIES), .IDXW(IDXW), .RST_CNT(1),
		.RST_E0(ftrm_pkg::PORT_DEFAULT), .RST_E1(ftrm_pkg::PORT_DEFAULT)
	) u_dst_port (
		.clk(clk), .arst_n(arst_n), .wr(wr_dp), .clr(clr), .wdata(new_port),
		.idx(idx_q), .rdata(dp_ent), .rd_ok(ok_s1.dst_port), .full(full.dst_port),
		.count(dp_cnt)
	);

	ftrm_list #(
		.WIDTH(8), .DEPTH(PROTO_ENTRIES), .IDXW(IDXW), .RST_CNT(2),
		.RST_E0(ftrm_pkg::PROTO_TCP), .RST_E1(ftrm_pkg::PROTO_UDP)
	) u_proto (
		.clk(clk), .arst_n(arst_n), .wr(wr_pr), .clr(clr), .wdata(cmd.entry_proto),
		.idx(idx_q), .rdata(pr_ent), .rd_ok(ok_s1.proto), .full(full.proto),
		.count(pr_cnt)
	);

	ftrm_cmp u_cmp (
		.pkt(pkt_q), .src_addr(sa_ent), .dst_addr(da_ent), .src_port(sp_ent),
		.dst_port(dp_ent), .proto(pr_ent), .hit(hit_cmp)
	);

	// Keep only hits from valid entries of a read issued last cycle
	assign hit_now = hit_cmp & ok_s1 & {$bits(ftrm_pkg::ftrm_hit_t){vld_s1}};

	// Select the full flag of the list an add item targets
	always_comb begin
		is_add   = 1'b1;
		full_sel = 1'b0;
		case (cmd.mode)
			ftrm_pkg::MODE_ADD_SADDR: full_sel = full.src_addr;
			ftrm_pkg::MODE_ADD_DADDR: full_sel = full.dst_addr;
			ftrm_pkg::MODE_ADD_SPORT: full_sel = full.src_port;
			ftrm_pkg::MODE_ADD_DPORT: full_sel = full.dst_port;
			ftrm_pkg::MODE_ADD_PROTO: full_sel = full.proto;
			default:                  is_add   = 1'b0;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ftrm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and scan control
	always_comb begin
		state_d  = state_q;
		scan_end = (idx_q >= last_q);
		issue    = 1'b0;
		finish   = 1'b0;
		case (state_q)
			ftrm_pkg::ST_IDLE: begin
				if (accept && is_match) begin
					state_d = ftrm_pkg::ST_SCAN;
				end
			end
			ftrm_pkg::ST_SCAN: begin
				issue  = !scan_end;
				finish = scan_end;
				if (scan_end) begin
					state_d = ftrm_pkg::ST_IDLE;
				end
			end
			default: state_d = ftrm_pkg::ST_IDLE;
		endcase
	end

	// Advance the scan index and read strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= issue;
			done_q <= (accept && !is_match) || finish;
			if (accept) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Latch the packet, gather hits, form the result beat
	always_ff @(posedge clk) begin
		if (accept) begin
			pkt_q  <= cmd;
			hit_q  <= '0;
			last_q <= max2(max2(max2(sa_cnt, da_cnt), max2(sp_cnt, dp_cnt)), pr_cnt);
		end else begin
			hit_q <= hit_q | hit_now;
		end
		result_q.matched  <= finish && (&(hit_q | hit_now));
		result_q.rejected <= accept && is_add && full_sel;
	end

	assign done   = done_q;
	assign result = result_q;

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.matched && result.rejected))
		else $error("result both matched and rejected");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while scan still running");

	a_upd_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.mode != ftrm_pkg::MODE_MATCH) |=> done)
		else $error("update item gave no result beat");

	a_match_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.mode == ftrm_pkg::MODE_MATCH) |=> (busy && !done))
		else $error("match item did not start a scan");

endmodule

// File: tb/sv/testbench.sv
// Testbench for the five-tuple rule matcher: directed table, rule-building random beats, scoreboard.
`timescale 1ns / 100ps

module testbench;

	localparam int ADDR_DEPTH   = 8;
	localparam int PORT_DEPTH   = 8;
	localparam int PROTO_DEPTH  = 8;
	localparam int RAND_ITEMS   = 1900;
	localparam int DRAIN_CYCLES = 16;
	// The block leaves this mode code unassigned
	localparam logic [2:0] MODE_UNUSED = 3'd7;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	ftrm_pkg::ftrm_in_t  cmd = '0;
	logic                done;
	ftrm_pkg::ftrm_out_t result;

	// Typed-in expectation that travels with a table beat
	logic                row_typed = 1'b0;
	ftrm_pkg::ftrm_out_t row_want = '0;

	five_tuple_rule_matcher #(
		.ADDR_ENTRIES (ADDR_DEPTH),
		.PORT_ENTRIES (PORT_DEPTH),
		.PROTO_ENTRIES(PROTO_DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd),
		.done  (done),
		.result(result)
	);

	always #2 clk = ~clk;

	// Rule held by the predictor
	ftrm_pkg::addr_ent_t rule_saddr [ADDR_DEPTH];
	ftrm_pkg::addr_ent_t rule_daddr [ADDR_DEPTH];
	ftrm_pkg::port_ent_t rule_sport [PORT_DEPTH];
	ftrm_pkg::port_ent_t rule_dport [PORT_DEPTH];
	logic [7:0]          rule_proto [PROTO_DEPTH];
	int rule_saddr_n = 1;
	int rule_daddr_n = 1;
	int rule_sport_n = 1;
	int rule_dport_n = 1;
	int rule_proto_n = 2;

	// Entries the stimulus has placed in the lists, used to aim packets at hits
	ftrm_pkg::addr_ent_t stim_saddr [$];
	ftrm_pkg::addr_ent_t stim_daddr [$];
	ftrm_pkg::port_ent_t stim_sport [$];
	ftrm_pkg::port_ent_t stim_dport [$];
	logic [7:0]          stim_proto [$];

	ftrm_pkg::ftrm_out_t outcome_q [$];
	ftrm_pkg::ftrm_out_t verdict_want;
	ftrm_pkg::ftrm_out_t verdict_pred;
	int errors = 0;
	int items_sent = 0;
	int hits_seen = 0;
	int refusals_seen = 0;
	int idle_pct = 19;

	// Work out the verdict of one beat and apply its effect on the rule
	function automatic ftrm_pkg::ftrm_out_t rule_outcome(ftrm_pkg::ftrm_in_t b);
		ftrm_pkg::ftrm_out_t o;
		bit hs, hd, hsp, hdp, hp;
		o = '0;
		hs = 0; hd = 0; hsp = 0; hdp = 0; hp = 0;
		case (b.mode)
			ftrm_pkg::MODE_MATCH: begin
				for (int i = 0; i < rule_saddr_n; i++)
					if ((b.pkt_src_addr & rule_saddr[i].mask) == rule_saddr[i].addr) hs = 1;
				for (int i = 0; i < rule_daddr_n; i++)
					if ((b.pkt_dst_addr & rule_daddr[i].mask) == rule_daddr[i].addr) hd = 1;
				for (int i = 0; i < rule_sport_n; i++)
					if (b.pkt_src_port >= rule_sport[i].lo && b.pkt_src_port <= rule_sport[i].hi)
						hsp = 1;
				for (int i = 0; i < rule_dport_n; i++)
					if (b.pkt_dst_port >= rule_dport[i].lo && b.pkt_dst_port <= rule_dport[i].hi)
						hdp = 1;
				for (int i = 0; i < rule_proto_n; i++)
					if (b.pkt_proto == rule_proto[i]) hp = 1;
				o.matched = hs & hd & hsp & hdp & hp;
			end
			ftrm_pkg::MODE_CLEAR: begin
				rule_saddr_n = 0;
				rule_daddr_n = 0;
				rule_sport_n = 0;
				rule_dport_n = 0;
				rule_proto_n = 0;
			end
			ftrm_pkg::MODE_ADD_SADDR: begin
				if (rule_saddr_n >= ADDR_DEPTH) o.rejected = 1'b1;
				else begin
					rule_saddr[rule_saddr_n] = '{addr: b.entry_address, mask: b.entry_mask};
					rule_saddr_n++;
				end
			end
			ftrm_pkg::MODE_ADD_DADDR: begin
				if (rule_daddr_n >= ADDR_DEPTH) o.rejected = 1'b1;
				else begin
					rule_daddr[rule_daddr_n] = '{addr: b.entry_address, mask: b.entry_mask};
					rule_daddr_n++;
				end
			end
			ftrm_pkg::MODE_ADD_SPORT: begin
				if (rule_sport_n >= PORT_DEPTH) o.rejected = 1'b1;
				else begin
					rule_sport[rule_sport_n] = '{lo: b.entry_port_low, hi: b.entry_port_high};
					rule_sport_n++;
				end
			end
			ftrm_pkg::MODE_ADD_DPORT: begin
				if (rule_dport_n >= PORT_DEPTH) o.rejected = 1'b1;
				else begin
					rule_dport[rule_dport_n] = '{lo: b.entry_port_low, hi: b.entry_port_high};
					rule_dport_n++;
				end
			end
			ftrm_pkg::MODE_ADD_PROTO: begin
				if (rule_proto_n >= PROTO_DEPTH) o.rejected = 1'b1;
				else begin
					rule_proto[rule_proto_n] = b.entry_proto;
					rule_proto_n++;
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	// Load the default record into the predictor
	initial begin
		rule_saddr[0] = ftrm_pkg::ADDR_DEFAULT;
		rule_daddr[0] = ftrm_pkg::ADDR_DEFAULT;
		rule_sport[0] = ftrm_pkg::PORT_DEFAULT;
		rule_dport[0] = ftrm_pkg::PORT_DEFAULT;
		rule_proto[0] = ftrm_pkg::PROTO_TCP;
		rule_proto[1] = ftrm_pkg::PROTO_UDP;
		stim_saddr = {stim_saddr, ftrm_pkg::ADDR_DEFAULT};
		stim_daddr = {stim_daddr, ftrm_pkg::ADDR_DEFAULT};
		stim_sport = {stim_sport, ftrm_pkg::PORT_DEFAULT};
		stim_dport = {stim_dport, ftrm_pkg::PORT_DEFAULT};
		stim_proto = {stim_proto, ftrm_pkg::PROTO_TCP};
		stim_proto = {stim_proto, ftrm_pkg::PROTO_UDP};
	end

	// Compare each result beat with the oldest verdict, then queue the verdict of a taken beat
	always @(posedge clk) begin
		if (done) begin
			if (outcome_q.size() == 0) begin
				$error("result beat with no item outstanding: matched=%0b rejected=%0b",
					result.matched, result.rejected);
				errors++;
			end else begin
				verdict_want = outcome_q.pop_front();
				if (result.matched !== verdict_want.matched) begin
					$error("matched: expected %0b, got %0b", verdict_want.matched, result.matched);
					errors++;
				end
				if (result.rejected !== verdict_want.rejected) begin
					$error("rejected: expected %0b, got %0b", verdict_want.rejected,
						result.rejected);
					errors++;
				end
			end
			if (result.matched === 1'b1) hits_seen++;
			if (result.rejected === 1'b1) refusals_seen++;
		end
		if (start && !busy) begin
			verdict_pred = rule_outcome(cmd);
			outcome_q = {outcome_q, (row_typed ? row_want : verdict_pred)};
		end
	end

	// Track which entries the stimulus has stored
	function automatic void note_stim(ftrm_pkg::ftrm_in_t b);
		ftrm_pkg::addr_ent_t ae;
		ftrm_pkg::port_ent_t pe;
		ae = '{addr: b.entry_address, mask: b.entry_mask};
		pe = '{lo: b.entry_port_low, hi: b.entry_port_high};
		case (b.mode)
			ftrm_pkg::MODE_CLEAR: begin
				stim_saddr.delete();
				stim_daddr.delete();
				stim_sport.delete();
				stim_dport.delete();
				stim_proto.delete();
			end
			ftrm_pkg::MODE_ADD_SADDR:
				if (stim_saddr.size() < ADDR_DEPTH) stim_saddr = {stim_saddr, ae};
			ftrm_pkg::MODE_ADD_DADDR:
				if (stim_daddr.size() < ADDR_DEPTH) stim_daddr = {stim_daddr, ae};
			ftrm_pkg::MODE_ADD_SPORT:
				if (stim_sport.size() < PORT_DEPTH) stim_sport = {stim_sport, pe};
			ftrm_pkg::MODE_ADD_DPORT:
				if (stim_dport.size() < PORT_DEPTH) stim_dport = {stim_dport, pe};
			ftrm_pkg::MODE_ADD_PROTO:
				if (stim_proto.size() < PROTO_DEPTH) stim_proto = {stim_proto, b.entry_proto};
			default: ;
		endcase
	endfunction

	// Offer one beat after a random idle stretch and hold it until taken
	task automatic send_beat(input ftrm_pkg::ftrm_in_t b, input bit typed,
			input ftrm_pkg::ftrm_out_t want);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start     <= 1'b1;
		cmd       <= b;
		row_typed <= typed;
		row_want  <= want;
		@(posedge clk);
		while (busy) @(posedge clk);
		items_sent++;
		note_stim(b);
	endtask

	function automatic ftrm_pkg::ftrm_in_t mk_beat(logic [2:0] mode, logic [31:0] psa,
			logic [31:0] pda, logic [15:0] psp, logic [15:0] pdp, logic [7:0] ppr,
			logic [31:0] ea, logic [31:0] em, logic [15:0] elo, logic [15:0] ehi,
			logic [7:0] epr);
		ftrm_pkg::ftrm_in_t b;
		b.mode = mode;
		b.pkt_src_addr = psa;
		b.pkt_dst_addr = pda;
		b.pkt_src_port = psp;
		b.pkt_dst_port = pdp;
		b.pkt_proto = ppr;
		b.entry_address = ea;
		b.entry_mask = em;
		b.entry_port_low = elo;
		b.entry_port_high = ehi;
		b.entry_proto = epr;
		return b;
	endfunction

	function automatic ftrm_pkg::ftrm_in_t rand_beat(logic [2:0] mode);
		return mk_beat(mode, $urandom, $urandom, 16'($urandom), 16'($urandom), 8'($urandom),
			$urandom, $urandom, 16'($urandom), 16'($urandom), 8'($urandom));
	endfunction

	function automatic ftrm_pkg::addr_ent_t rand_addr_entry();
		ftrm_pkg::addr_ent_t e;
		int plen;
		int pick;
		plen = $urandom_range(0, 32);
		e.mask = (plen == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - plen));
		pick = $urandom_range(99);
		// Mostly clean prefixes; some stray address bits, some scattered masks
		if (pick < 10) e.mask = $urandom;
		e.addr = $urandom & e.mask;
		if (pick >= 85) e.addr = $urandom;
		return e;
	endfunction

	function automatic ftrm_pkg::port_ent_t rand_port_entry();
		ftrm_pkg::port_ent_t e;
		int pick;
		pick = $urandom_range(99);
		e.lo = 16'($urandom_range(0, 65535));
		e.hi = 16'($urandom_range(65535, e.lo));
		if (pick < 10) e = '{lo: e.hi, hi: e.lo};
		else if (pick < 20) e = ftrm_pkg::PORT_DEFAULT;
		else if (pick < 30) e.hi = e.lo;
		return e;
	endfunction

	// Add one entry with shaped content to the list that the mode names
	task automatic send_add(input logic [2:0] mode);
		ftrm_pkg::ftrm_in_t  b;
		ftrm_pkg::addr_ent_t ae;
		ftrm_pkg::port_ent_t pe;
		b = rand_beat(mode);
		ae = rand_addr_entry();
		pe = rand_port_entry();
		b.entry_address = ae.addr;
		b.entry_mask = ae.mask;
		b.entry_port_low = pe.lo;
		b.entry_port_high = pe.hi;
		if ($urandom_range(99) < 30)
			b.entry_proto = $urandom_range(1) ? ftrm_pkg::PROTO_TCP : ftrm_pkg::PROTO_UDP;
		send_beat(b, 1'b0, '0);
	endtask

	// Send a packet aimed, field by field, mostly at stored entries
	task automatic send_match();
		ftrm_pkg::ftrm_in_t  b;
		ftrm_pkg::addr_ent_t ae;
		ftrm_pkg::port_ent_t pe;
		b = rand_beat(ftrm_pkg::MODE_MATCH);
		if (stim_saddr.size() != 0 && $urandom_range(99) < 88) begin
			ae = stim_saddr[$urandom_range(stim_saddr.size() - 1)];
			b.pkt_src_addr = ae.addr | ($urandom & ~ae.mask);
		end
		if (stim_daddr.size() != 0 && $urandom_range(99) < 88) begin
			ae = stim_daddr[$urandom_range(stim_daddr.size() - 1)];
			b.pkt_dst_addr = ae.addr | ($urandom & ~ae.mask);
		end
		if (stim_sport.size() != 0 && $urandom_range(99) < 88) begin
			pe = stim_sport[$urandom_range(stim_sport.size() - 1)];
			if (pe.lo <= pe.hi) b.pkt_src_port = 16'($urandom_range(pe.hi, pe.lo));
		end
		if (stim_dport.size() != 0 && $urandom_range(99) < 88) begin
			pe = stim_dport[$urandom_range(stim_dport.size() - 1)];
			if (pe.lo <= pe.hi) b.pkt_dst_port = 16'($urandom_range(pe.hi, pe.lo));
		end
		if (stim_proto.size() != 0 && $urandom_range(99) < 88)
			b.pkt_proto = stim_proto[$urandom_range(stim_proto.size() - 1)];
		send_beat(b, 1'b0, '0);
	endtask

	typedef struct {
		ftrm_pkg::ftrm_in_t  beat;
		bit                  typed;
		ftrm_pkg::ftrm_out_t want;
	} stim_row_t;

	stim_row_t dir_rows [$];

	task automatic add_row(input ftrm_pkg::ftrm_in_t b, input bit typed, input bit m,
			input bit r);
		stim_row_t row;
		row.beat = b;
		row.typed = typed;
		row.want = '{matched: m, rejected: r};
		dir_rows = {dir_rows, row};
	endtask

	// Main sequence
	initial begin
		logic [2:0] fill_mode;
		int nadd;
		int nmatch;
		logic [7:0] dir_protos [8];

		dir_protos = '{8'd0, 8'd255, ftrm_pkg::PROTO_TCP, ftrm_pkg::PROTO_UDP,
			8'd1, 8'd2, 8'd3, 8'd4};

		// Default record accepts everything on TCP and UDP
		add_row(mk_beat(ftrm_pkg::MODE_MATCH, '0, '0, '0, '0, ftrm_pkg::PROTO_TCP,
			'0, '0, '0, '0, '0), 1'b1, 1'b1, 1'b0);
		add_row(mk_beat(ftrm_pkg::MODE_MATCH, '1, '1, '1, '1, ftrm_pkg::PROTO_UDP,
			'1, '1, '1, '1, '1), 1'b1, 1'b1, 1'b0);
		add_row(mk_beat(ftrm_pkg::MODE_MATCH, '1, '1, '1, '1, 8'd0, '1, '1, '1, '1, '1),
			1'b1, 1'b0, 1'b0);
		add_row(mk_beat(MODE_UNUSED, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1),
			1'b1, 1'b0, 1'b0);
		add_row(mk_beat(ftrm_pkg::MODE_ADD_SPORT, '0, '0, '0, '0, '0, '0, '0,
			16'd1000, 16'd2000, '0), 1'b1, 1'b0, 1'b0);
		// Empty lists match nothing
		add_row(mk_beat(ftrm_pkg::MODE_CLEAR, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1),
			1'b1, 1'b0, 1'b0);
		add_row(mk_beat(ftrm_pkg::MODE_MATCH, '0, '0, '0, '0, ftrm_pkg::PROTO_TCP,
			'0, '0, '0, '0, '0), 1'b1, 1'b0, 1'b0);
		// Fill the protocol list, then overflow it
		foreach (dir_protos[i])
			add_row(mk_beat(ftrm_pkg::MODE_ADD_PROTO, '0, '0, '0, '0, '0, '0, '0, '0, '0,
				dir_protos[i]), 1'b1, 1'b0, 1'b0);
		add_row(mk_beat(ftrm_pkg::MODE_ADD_PROTO, '0, '0, '0, '0, '0, '0, '0, '0, '0,
			8'd99), 1'b1, 1'b0, 1'b1);
		add_row(mk_beat(ftrm_pkg::MODE_ADD_SADDR, '0, '0, '0, '0, '0, 32'hC0A8_0000,
			32'hFFFF_0000, '0, '0, '0), 1'b1, 1'b0, 1'b0);
		// Address bits outside the mask never accept
		add_row(mk_beat(ftrm_pkg::MODE_ADD_SADDR, '0, '0, '0, '0, '0, 32'hFFFF_FFFF,
			32'h0, '0, '0, '0), 1'b1, 1'b0, 1'b0);
		add_row(mk_beat(ftrm_pkg::MODE_ADD_DADDR, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0),
			1'b1, 1'b0, 1'b0);
		add_row(mk_beat(ftrm_pkg::MODE_ADD_SPORT, '0, '0, '0, '0, '0, '0, '0,
			16'd0, ftrm_pkg::PORT_MAX, '0), 1'b1, 1'b0, 1'b0);
		// Inverted range is stored but never accepts
		add_row(mk_beat(ftrm_pkg::MODE_ADD_DPORT, '0, '0, '0, '0, '0, '0, '0,
			16'd100, 16'd50, '0), 1'b1, 1'b0, 1'b0);
		add_row(mk_beat(ftrm_pkg::MODE_MATCH, 32'hC0A8_0101, 32'h1234_5678, '0, 16'd75,
			8'd255, '0, '0, '0, '0, '0), 1'b0, 1'b0, 1'b0);
		add_row(mk_beat(ftrm_pkg::MODE_ADD_DPORT, '0, '0, '0, '0, '0, '0, '0,
			ftrm_pkg::PORT_MAX, ftrm_pkg::PORT_MAX, '0), 1'b1, 1'b0, 1'b0);
		add_row(mk_beat(ftrm_pkg::MODE_MATCH, 32'hC0A8_FFFF, 32'hFFFF_FFFF,
			ftrm_pkg::PORT_MAX, ftrm_pkg::PORT_MAX, 8'd255, '0, '0, '0, '0, '0),
			1'b0, 1'b0, 1'b0);
		add_row(mk_beat(ftrm_pkg::MODE_MATCH, 32'h0A00_0001, '0, 16'd7, ftrm_pkg::PORT_MAX,
			8'd4, '0, '0, '0, '0, '0), 1'b0, 1'b0, 1'b0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (dir_rows[i])
			send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);

		// Random part: mostly rule builds followed by packets, with some noise
		while (items_sent < RAND_ITEMS + dir_rows.size()) begin
			if (items_sent < RAND_ITEMS / 3) idle_pct = 19;
			else if (items_sent < 2 * RAND_ITEMS / 3) idle_pct = 51;
			else idle_pct = 0;
			if ($urandom_range(99) < 80) begin
				if ($urandom_range(99) < 85)
					send_beat(rand_beat(ftrm_pkg::MODE_CLEAR), 1'b0, '0);
				nadd = $urandom_range(0, 14);
				repeat (nadd)
					send_add(3'(ftrm_pkg::MODE_ADD_SADDR + $urandom_range(0, 4)));
				// Now and then push one list past full
				if ($urandom_range(99) < 15) begin
					fill_mode = 3'(ftrm_pkg::MODE_ADD_SADDR + $urandom_range(0, 4));
					repeat ($urandom_range(9, 10)) send_add(fill_mode);
				end
				nmatch = $urandom_range(1, 10);
				repeat (nmatch) send_match();
			end else begin
				send_beat(rand_beat(3'($urandom_range(0, 7))), 1'b0, '0);
			end
		end

		// Drain outstanding results
		start <= 1'b0;
		while (outcome_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d beats through the rule lists under three idle profiles.", items_sent);
		$display("Packets matched: %0d, list-full refusals: %0d, mismatches: %0d.",
			hits_seen, refusals_seen, errors);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2ms;
		$display("Watchdog expired with %0d results outstanding", outcome_q.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule
